// ===== sv/spq_pkg.sv =====
package spq_pkg;

  localparam int unsigned IdW        = 16;
  localparam int unsigned LevelW     = 3;
  localparam int unsigned KindW      = 2;
  localparam int unsigned ModeW      = 2;
  localparam int unsigned TdataW     = 24;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned DrainCntW  = $clog2(MaxResults + 1);

  localparam logic [LevelW-1:0] TopLevel = 3'd4;

  localparam logic [ModeW-1:0] ModeAdd      = 2'd0;
  localparam logic [ModeW-1:0] ModeServeOne = 2'd1;
  localparam logic [ModeW-1:0] ModeServeAll = 2'd2;

  typedef enum logic [KindW-1:0] {
    KindAdded   = 2'd0,
    KindDropped = 2'd1,
    KindServed  = 2'd2,
    KindEmpty   = 2'd3
  } kind_e;

  typedef struct packed {
    logic              insert;
    logic              pop;
    logic [IdW-1:0]    id;
    logic [LevelW-1:0] level;
  } dp_cmd_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic              last_one;
    logic [IdW-1:0]    head_id;
    logic [LevelW-1:0] head_level;
  } dp_status_t;

endpackage

// ===== sv/spq_datapath.sv =====
module spq_datapath #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spq_pkg::dp_cmd_t    cmd_i,
  output spq_pkg::dp_status_t status_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [IdW-1:0]    tag_q   [QUEUE_DEPTH];
  logic [LevelW-1:0] level_q [QUEUE_DEPTH];
  logic [CntW-1:0]   count_q;
  logic [CntW-1:0]   count_d;
  logic [LevelW-1:0] new_level;
  logic              full;
  logic [QUEUE_DEPTH-1:0] keep;

  assign full      = (count_q == CntW'(QUEUE_DEPTH));
  assign new_level = (cmd_i.level > TopLevel) ? TopLevel : cmd_i.level;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      keep[i] = (CntW'(i) < count_q) && (level_q[i] >= new_level);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert && !full) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (!keep[i]) begin
          if (i == 0) begin
            tag_q[i]   <= cmd_i.id;
            level_q[i] <= new_level;
          end else if (keep[i-1]) begin
            tag_q[i]   <= cmd_i.id;
            level_q[i] <= new_level;
          end else begin
            tag_q[i]   <= tag_q[i-1];
            level_q[i] <= level_q[i-1];
          end
        end
      end
    end else if (cmd_i.pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        tag_q[i]   <= tag_q[i+1];
        level_q[i] <= level_q[i+1];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.insert && !full) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.pop && (count_q != '0)) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign status_o.empty      = (count_q == '0);
  assign status_o.full       = full;
  assign status_o.last_one   = (count_q == CntW'(1));
  assign status_o.head_id    = tag_q[0];
  assign status_o.head_level = level_q[0];

endmodule

// ===== sv/spq_ctrl.sv =====
module spq_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_tvalid_i,
  output logic                       s_tready_o,
  input  logic [spq_pkg::ModeW-1:0]  in_mode_i,
  input  logic [spq_pkg::IdW-1:0]    in_id_i,
  input  logic [spq_pkg::LevelW-1:0] in_level_i,
  output logic                       m_tvalid_o,
  input  logic                       m_tready_i,
  output logic [spq_pkg::KindW-1:0]  out_kind_o,
  output logic [spq_pkg::IdW-1:0]    out_id_o,
  output logic [spq_pkg::LevelW-1:0] out_level_o,
  output logic                       out_last_o,
  output spq_pkg::dp_cmd_t           cmd_o,
  input  spq_pkg::dp_status_t        status_i
);
  import spq_pkg::*;

  localparam logic StIdle  = 1'b0;
  localparam logic StDrain = 1'b1;

  logic                 state_q, state_d;
  logic                 valid_q, valid_d;
  logic [KindW-1:0]     kind_q, kind_d;
  logic [IdW-1:0]       id_q, id_d;
  logic [LevelW-1:0]    level_q, level_d;
  logic                 last_q, last_d;
  logic [DrainCntW-1:0] cnt_q, cnt_d;
  logic                 slot_free;
  logic                 accept;
  logic                 load;

  assign slot_free  = !valid_q || m_tready_i;
  assign s_tready_o = (state_q == StIdle) && slot_free;
  assign accept     = s_tvalid_i && s_tready_o;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    load        = 1'b0;
    kind_d      = kind_q;
    id_d        = id_q;
    level_d     = level_q;
    last_d      = last_q;
    cmd_o       = '0;
    cmd_o.id    = in_id_i;
    cmd_o.level = in_level_i;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          id_d    = '0;
          level_d = '0;
          last_d  = 1'b1;
          unique case (in_mode_i) inside
            ModeAdd: begin
              load         = 1'b1;
              cmd_o.insert = 1'b1;
              kind_d       = status_i.full ? KindDropped : KindAdded;
            end
            ModeServeOne, ModeServeAll: begin
              load = 1'b1;
              if (status_i.empty) begin
                kind_d = KindEmpty;
              end else begin
                cmd_o.pop = 1'b1;
                kind_d    = KindServed;
                id_d      = status_i.head_id;
                level_d   = status_i.head_level;
                if (in_mode_i == ModeServeAll) begin
                  last_d = status_i.last_one || (MaxResults == 1);
                  cnt_d  = DrainCntW'(1);
                  if (!last_d) begin
                    state_d = StDrain;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      StDrain: begin
        if (slot_free) begin
          load      = 1'b1;
          cmd_o.pop = 1'b1;
          kind_d    = KindServed;
          id_d      = status_i.head_id;
          level_d   = status_i.head_level;
          last_d    = status_i.last_one || (cnt_q == DrainCntW'(MaxResults - 1));
          cnt_d     = cnt_q + DrainCntW'(1);
          if (last_d) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    if (load) begin
      valid_d = 1'b1;
    end else if (m_tready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    id_q    <= id_d;
    level_q <= level_d;
    last_q  <= last_d;
  end

  assign m_tvalid_o  = valid_q;
  assign out_kind_o  = kind_q;
  assign out_id_o    = id_q;
  assign out_level_o = level_q;
  assign out_last_o  = last_q;

endmodule

// ===== sv/stable_priority_queue.sv =====
// Stable priority queue: entries sorted by level (4 highest), FIFO within a level.
// Input channel s_*: one transaction is a command. mode 0 adds customer_id at
// priority_level (5..7 count as 4), mode 1 serves the head, mode 2 drains the
// queue, mode 3 is ignored and gives no result.
// Output channel m_*: one transaction per result; tlast marks the final result
// of a command. Add gives added or dropped (queue full); a serve on an empty
// queue gives one empty result. A drain gives up to 16 served results per command.
// A result is registered and shows in the cycle after its command is taken.
// Throughput: one command per cycle for add, serve-one and mode 3 while results are
// taken, since insert and pop are each a single shift of the sorted register file.
// A drain pops one entry per cycle while results are taken; it takes no new command.
// When the receiver stalls, the output register holds its result, the queue
// does not move, and s_tready_o drops until the result is taken.
// Reset clears the entry count and the output valid; the queue starts empty.
module stable_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  output logic                        s_tready_o,
  // [1:0] mode, [17:2] customer_id, [20:18] priority_level, [23:21] zero
  input  logic [spq_pkg::TdataW-1:0]  s_tdata_i,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  // [1:0] result_kind, [17:2] served_id, [20:18] served_level, [23:21] zero
  output logic [spq_pkg::TdataW-1:0]  m_tdata_o,
  output logic                        m_tlast_o
);
  import spq_pkg::*;

  dp_cmd_t           cmd;
  dp_status_t        status;
  logic [KindW-1:0]  out_kind;
  logic [IdW-1:0]    out_id;
  logic [LevelW-1:0] out_level;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .in_mode_i   (s_tdata_i[1:0]),
    .in_id_i     (s_tdata_i[17:2]),
    .in_level_i  (s_tdata_i[20:18]),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .out_kind_o  (out_kind),
    .out_id_o    (out_id),
    .out_level_o (out_level),
    .out_last_o  (m_tlast_o),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status)
  );

  assign m_tdata_o = {3'b000, out_level, out_id, out_kind};

endmodule
